// ----- hw/rtl/i2crm_pkg.sv -----
// Shared types and constants of the I2C register master.
package i2crm_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_BEGIN = 2'd1,
    REQ_BYTE  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW,
    PH_ACK_HIGH, PH_WAIT_BYTE, PH_RS_PREP, PH_RX_LOW, PH_RX_HIGH,
    PH_MACK_LOW, PH_MACK_HIGH, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  typedef enum logic [1:0] {
    ST_ADDR_W, ST_REG, ST_ADDR_R, ST_DATA
  } stage_t;

  localparam logic [1:0] CFG_START_HOLD = 2'd0;
  localparam logic [1:0] CFG_HALF_BIT   = 2'd1;
  localparam logic [1:0] CFG_ACK_TMO    = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        sda_in;
    logic        is_read;
    logic [7:0]  addr_byte;
    logic [7:0]  reg_addr;
    logic [15:0] length;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_release;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       want_byte;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
  } out_item_t;

endpackage

// ----- hw/rtl/i2crm_queue.sv -----
// Two-entry queue between the input stage and the bus engine.
module i2crm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2crm_pkg::in_item_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output i2crm_pkg::in_item_t pop_data
);
  import i2crm_pkg::*;

  in_item_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- hw/rtl/i2crm_engine.sv -----
// Bus engine: runs the transaction phases one tick per item and registers the result.
module i2crm_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          start_hold_ticks,
  input  logic [7:0]          half_bit_ticks,
  input  logic [7:0]          ack_timeout,
  input  logic                in_valid,
  input  i2crm_pkg::in_item_t in_data,
  output logic                in_take,
  output logic                out_valid,
  output i2crm_pkg::out_item_t out_data,
  input  logic                out_stall
);
  import i2crm_pkg::*;

  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [7:0]  tick_count, tick_count_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  ack_polls, ack_polls_next;
  logic        read_mode, read_mode_next;
  logic        error_flag, error_flag_next;
  logic [7:0]  saved_addr, saved_addr_next;
  logic [7:0]  saved_reg, saved_reg_next;
  out_item_t   res;

  logic [7:0]  hold_lim, half_lim, tick_inc;
  logic        hold_done, half_done;
  logic [7:0]  rx_shift;
  logic [15:0] left_dec;

  // The result register frees whenever it is empty or being taken.
  assign in_take = in_valid && (!out_valid || !out_stall);

  assign hold_lim  = (start_hold_ticks == 8'd0) ? 8'd1 : start_hold_ticks;
  assign half_lim  = (half_bit_ticks == 8'd0) ? 8'd1 : half_bit_ticks;
  assign tick_inc  = tick_count + 8'd1;
  assign hold_done = tick_inc >= hold_lim;
  assign half_done = tick_inc >= half_lim;
  assign rx_shift  = {shift_byte[6:0], in_data.sda_in};
  assign left_dec  = bytes_left - 16'd1;

  always_comb begin
    phase_next      = phase;
    stage_next      = stage;
    tick_count_next = tick_count;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    bytes_left_next = bytes_left;
    ack_polls_next  = ack_polls;
    read_mode_next  = read_mode;
    error_flag_next = error_flag;
    saved_addr_next = saved_addr;
    saved_reg_next  = saved_reg;
    res             = '0;

    case (phase)
      PH_IDLE: begin
        if (in_data.req_type == REQ_BEGIN) begin
          read_mode_next  = in_data.is_read;
          saved_addr_next = in_data.addr_byte;
          saved_reg_next  = in_data.reg_addr;
          bytes_left_next = (in_data.length == 16'd0) ? 16'd1 : in_data.length;
          error_flag_next = 1'b0;
          stage_next      = ST_ADDR_W;
          phase_next      = PH_START_A;
          tick_count_next = 8'd0;
        end
      end
      PH_START_A, PH_STOP_A: begin
        tick_count_next = hold_done ? 8'd0 : tick_inc;
        if (hold_done) phase_next = (phase == PH_START_A) ? PH_START_B : PH_STOP_B;
      end
      PH_START_B: begin
        tick_count_next = hold_done ? 8'd0 : tick_inc;
        if (hold_done) begin
          shift_byte_next = (stage == ST_ADDR_R) ? saved_addr + 8'd1 : saved_addr;
          bit_count_next  = 4'd0;
          phase_next      = PH_TX_LOW;
        end
      end
      PH_STOP_C: begin
        tick_count_next = hold_done ? 8'd0 : tick_inc;
        if (hold_done) begin
          res.done_res   = 1'b1;
          res.nack_error = error_flag;
          phase_next     = PH_IDLE;
        end
      end
      PH_TX_LOW, PH_RX_LOW, PH_MACK_LOW, PH_RS_PREP, PH_STOP_B: begin
        tick_count_next = half_done ? 8'd0 : tick_inc;
        if (half_done) begin
          case (phase)
            PH_TX_LOW:   phase_next = PH_TX_HIGH;
            PH_RX_LOW:   phase_next = PH_RX_HIGH;
            PH_MACK_LOW: phase_next = PH_MACK_HIGH;
            PH_RS_PREP:  phase_next = PH_START_A;
            default:     phase_next = PH_STOP_C;
          endcase
        end
      end
      PH_TX_HIGH: begin
        tick_count_next = half_done ? 8'd0 : tick_inc;
        if (half_done) begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_count_next  = bit_count + 4'd1;
          phase_next      = (bit_count_next >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
        end
      end
      PH_ACK_LOW: begin
        tick_count_next = half_done ? 8'd0 : tick_inc;
        if (half_done) begin
          ack_polls_next = 8'd0;
          phase_next     = PH_ACK_HIGH;
        end
      end
      PH_ACK_HIGH: begin
        if (!in_data.sda_in) begin
          tick_count_next = 8'd0;
          case (stage)
            ST_ADDR_W: begin
              stage_next      = ST_REG;
              shift_byte_next = saved_reg;
              bit_count_next  = 4'd0;
              phase_next      = PH_TX_LOW;
            end
            ST_REG: begin
              stage_next = read_mode ? ST_ADDR_R : ST_DATA;
              phase_next = read_mode ? PH_RS_PREP : PH_WAIT_BYTE;
            end
            ST_ADDR_R: begin
              bit_count_next  = 4'd0;
              shift_byte_next = 8'd0;
              phase_next      = PH_RX_LOW;
            end
            default: begin
              bytes_left_next = left_dec;
              phase_next      = (left_dec == 16'd0) ? PH_STOP_A : PH_WAIT_BYTE;
            end
          endcase
        end else if (ack_polls >= ack_timeout) begin
          error_flag_next = 1'b1;
          phase_next      = PH_STOP_A;
          tick_count_next = 8'd0;
        end else begin
          ack_polls_next = ack_polls + 8'd1;
        end
      end
      PH_WAIT_BYTE: begin
        if (in_data.req_type == REQ_BYTE) begin
          shift_byte_next = in_data.write_byte;
          bit_count_next  = 4'd0;
          tick_count_next = 8'd0;
          phase_next      = PH_TX_LOW;
        end
      end
      PH_RX_HIGH: begin
        tick_count_next = half_done ? 8'd0 : tick_inc;
        if (half_done) begin
          shift_byte_next = rx_shift;
          bit_count_next  = bit_count + 4'd1;
          if (bit_count_next >= 4'd8) begin
            res.rx_valid = 1'b1;
            res.rx_byte  = rx_shift;
            phase_next   = PH_MACK_LOW;
          end else begin
            phase_next = PH_RX_LOW;
          end
        end
      end
      PH_MACK_HIGH: begin
        tick_count_next = half_done ? 8'd0 : tick_inc;
        if (half_done) begin
          bytes_left_next = left_dec;
          if (left_dec == 16'd0) begin
            phase_next = PH_STOP_A;
          end else begin
            bit_count_next  = 4'd0;
            shift_byte_next = 8'd0;
            phase_next      = PH_RX_LOW;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = 8'd0;
      end
    endcase

    // Line drive follows the phase reached after this tick.
    res.scl     = 1'b1;
    res.sda_out = 1'b1;
    case (phase_next)
      PH_START_B: res.sda_out = 1'b0;
      PH_TX_LOW: begin
        res.scl     = 1'b0;
        res.sda_out = shift_byte_next[7];
      end
      PH_TX_HIGH: res.sda_out = shift_byte_next[7];
      PH_ACK_LOW, PH_WAIT_BYTE, PH_RX_LOW: begin
        res.scl         = 1'b0;
        res.sda_release = 1'b1;
      end
      PH_ACK_HIGH, PH_RX_HIGH: res.sda_release = 1'b1;
      PH_RS_PREP: res.scl = 1'b0;
      PH_MACK_LOW: begin
        res.scl     = 1'b0;
        res.sda_out = (bytes_left_next == 16'd1);
      end
      PH_MACK_HIGH: res.sda_out = (bytes_left_next == 16'd1);
      PH_STOP_A: begin
        res.scl     = 1'b0;
        res.sda_out = 1'b0;
      end
      PH_STOP_B: res.sda_out = 1'b0;
      default: ;
    endcase
    res.want_byte = (phase_next == PH_WAIT_BYTE);
    res.busy_res  = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      stage      <= ST_ADDR_W;
      tick_count <= 8'd0;
      bit_count  <= 4'd0;
      shift_byte <= 8'd0;
      bytes_left <= 16'd0;
      ack_polls  <= 8'd0;
      read_mode  <= 1'b0;
      error_flag <= 1'b0;
      saved_addr <= 8'd0;
      saved_reg  <= 8'd0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        phase      <= phase_next;
        stage      <= stage_next;
        tick_count <= tick_count_next;
        bit_count  <= bit_count_next;
        shift_byte <= shift_byte_next;
        bytes_left <= bytes_left_next;
        ack_polls  <= ack_polls_next;
        read_mode  <= read_mode_next;
        error_flag <= error_flag_next;
        saved_addr <= saved_addr_next;
        saved_reg  <= saved_reg_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) out_data <= res;
  end
endmodule

// ----- hw/rtl/i2c_register_master_unit.sv -----
// Top level of the I2C register master: configuration, input queue and bus engine.
// Each input item is one bus tick and yields exactly one result item; with no stall on
// either side the block takes one tick per clock cycle, and each tick is stored in an input
// queue slot and its result then in the engine's result register before the result
// appears. The engine's phase state machine updates once per tick and sets that rate.
module i2c_register_master_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2crm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2crm_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);
  import i2crm_pkg::*;

  logic [7:0] start_hold_ticks, half_bit_ticks, ack_timeout;
  logic       q_full, q_nonempty, q_pop, q_push;
  in_item_t   q_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_hold_ticks <= 8'd4;
      half_bit_ticks   <= 8'd2;
      ack_timeout      <= 8'd250;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_HOLD: start_hold_ticks <= cfg_data;
        CFG_HALF_BIT:   half_bit_ticks   <= cfg_data;
        CFG_ACK_TMO:    ack_timeout      <= cfg_data;
        default: ;
      endcase
    end
  end

  i2crm_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(in_data), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .pop_data(q_data)
  );

  i2crm_engine u_engine (
    .clk(clk), .rst(rst),
    .start_hold_ticks(start_hold_ticks), .half_bit_ticks(half_bit_ticks),
    .ack_timeout(ack_timeout),
    .in_valid(q_nonempty), .in_data(q_data), .in_take(q_pop),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );
endmodule
